// ===== src/three_tap_pixel_smoother_defines.svh =====
`ifndef THREE_TAP_PIXEL_SMOOTHER_DEFINES_SVH
`define THREE_TAP_PIXEL_SMOOTHER_DEFINES_SVH

// checks that sleep while reset is asserted
`define TTPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checks that also hold while reset is asserted
`define TTPS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/ttps_pkg.sv =====
`default_nettype none

package ttps_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;
    localparam int CHAN_W    = 8;
    localparam int PIX_W     = 4 * CHAN_W;
    localparam int POS_W     = 11;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

    // floor(s / 3) for s <= 765 as (s * 683) >> 11
    localparam int SUM_W      = CHAN_W + 2;
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;
    localparam int PROD_W     = 2 * SUM_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] alpha;
    } pixel_t;

    function automatic logic [CHAN_W-1:0] avg3_chan(
        input logic [CHAN_W-1:0] a,
        input logic [CHAN_W-1:0] b,
        input logic [CHAN_W-1:0] c
    );
        logic [SUM_W-1:0]  sum;
        logic [PROD_W-1:0] prod;
        sum  = SUM_W'(a) + SUM_W'(b) + SUM_W'(c);
        prod = PROD_W'(sum) * PROD_W'(DIV3_MUL);
        return prod[DIV3_SHIFT +: CHAN_W];
    endfunction

    function automatic pixel_t avg3(
        input pixel_t a,
        input pixel_t b,
        input pixel_t c
    );
        pixel_t r;
        r.alpha = avg3_chan(a.alpha, b.alpha, c.alpha);
        r.red   = avg3_chan(a.red,   b.red,   c.red);
        r.green = avg3_chan(a.green, b.green, c.green);
        r.blue  = avg3_chan(a.blue,  b.blue,  c.blue);
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/ttps_ram.sv =====
`default_nettype none

module ttps_ram #(
    parameter int WIDTH = ttps_pkg::PIX_W,
    parameter int DEPTH = ttps_pkg::DEF_MAX_WIDTH,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr_a,
    input  wire logic [ADDR_W-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]  rd_data_a,
    output logic      [WIDTH-1:0]  rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old word when the same address is written in that cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/three_tap_pixel_smoother.sv =====
// an accepted pixel passes the input register stage, then the result register stage
// throughput: one pixel per cycle while results are taken; a last-row pixel gives two
//   results (one in a one-row frame) and holds the input stage until both are taken
// the line store ram reads both neighbors above at the cycle the pixel is accepted
// reset: counters at zero, width 640, height 480, no item held; the line store
//   keeps whatever it holds and is rewritten by row 0 of every frame
`default_nettype none

module three_tap_pixel_smoother #(
    parameter int MAX_WIDTH  = ttps_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ttps_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           cfg_wr_en,
    input  wire logic [ttps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ttps_pkg::CFG_W-1:0]     cfg_data,

    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [ttps_pkg::CHAN_W-1:0]    in_alpha,
    input  wire logic [ttps_pkg::CHAN_W-1:0]    in_red,
    input  wire logic [ttps_pkg::CHAN_W-1:0]    in_green,
    input  wire logic [ttps_pkg::CHAN_W-1:0]    in_blue,

    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [ttps_pkg::POS_W-1:0]     out_col,
    output logic      [ttps_pkg::POS_W-1:0]     out_row,
    output logic      [ttps_pkg::CHAN_W-1:0]    out_alpha,
    output logic      [ttps_pkg::CHAN_W-1:0]    out_red,
    output logic      [ttps_pkg::CHAN_W-1:0]    out_green,
    output logic      [ttps_pkg::CHAN_W-1:0]    out_blue,
    output logic                                run_last
);

    `include "three_tap_pixel_smoother_defines.svh"

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int MAXCR = (CW > RW) ? CW : RW;
    localparam int SZ_W  = (MAXCR + 1 > ttps_pkg::CFG_W) ? MAXCR + 1 : ttps_pkg::CFG_W;

    // configuration
    logic [ttps_pkg::CFG_W-1:0] frame_width_reg;
    logic [ttps_pkg::CFG_W-1:0] frame_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= ttps_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= ttps_pkg::FRAME_HEIGHT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (ttps_pkg::cfg_index_t'(cfg_index))
                ttps_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                ttps_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective frame size: zero counts as one, too large saturates
    logic [SZ_W-1:0] w_eff;
    logic [SZ_W-1:0] h_eff;

    always_comb
    begin
        if (frame_width_reg == '0)
            w_eff = SZ_W'(1);
        else if (SZ_W'(frame_width_reg) > SZ_W'(MAX_WIDTH))
            w_eff = SZ_W'(MAX_WIDTH);
        else
            w_eff = SZ_W'(frame_width_reg);

        if (frame_height_reg == '0)
            h_eff = SZ_W'(1);
        else if (SZ_W'(frame_height_reg) > SZ_W'(MAX_HEIGHT))
            h_eff = SZ_W'(MAX_HEIGHT);
        else
            h_eff = SZ_W'(frame_height_reg);
    end

    // position of the next pixel
    logic [CW-1:0]   col_reg, col_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [SZ_W-1:0] col_inc, row_inc;
    logic            x_end, last_row, has_right, has_above;
    logic            in_fire;

    ttps_pkg::pixel_t in_pix;

    assign in_pix.alpha = in_alpha;
    assign in_pix.red   = in_red;
    assign in_pix.green = in_green;
    assign in_pix.blue  = in_blue;

    assign in_fire   = in_valid && in_ready;
    assign col_inc   = SZ_W'(col_reg) + SZ_W'(1);
    assign row_inc   = SZ_W'(row_reg) + SZ_W'(1);
    assign x_end     = (col_inc >= w_eff);
    assign last_row  = (row_inc >= h_eff);
    assign has_above = (row_reg != '0);
    assign has_right = (col_inc < w_eff) && (col_inc < SZ_W'(MAX_WIDTH))
                    && (SZ_W'(row_reg) < h_eff);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_fire)
        begin
            if (x_end)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_inc[RW-1:0];
            end
            else
            begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line store: read the two pixels above, then overwrite the left one
    ttps_pkg::pixel_t above_pix, right_pix;

    ttps_ram #(
        .WIDTH (ttps_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk       (clk),
        .wr_en     (in_fire),
        .wr_addr   (col_reg),
        .wr_data   (in_pix),
        .rd_en     (in_fire),
        .rd_addr_a (col_reg),
        .rd_addr_b (col_inc[CW-1:0]),
        .rd_data_a (above_pix),
        .rd_data_b (right_pix)
    );

    // input register stage
    logic             s1_valid_reg;
    ttps_pkg::pixel_t s1_pix_reg;
    logic [CW-1:0]    s1_col_reg;
    logic [RW-1:0]    s1_row_reg;
    logic             s1_above_reg;
    logic             s1_last_reg;
    logic             s1_right_reg;
    logic             s1_advance;
    logic             drain;

    // result register stage: result of the row above, then the pixel itself
    logic             pend_a_reg;
    logic             pend_b_reg;
    ttps_pkg::pixel_t oa_pix_reg;
    ttps_pkg::pixel_t ob_pix_reg;
    logic [CW-1:0]    o_col_reg;
    logic [RW-1:0]    o_row_reg;
    logic             out_fire;
    logic             both_pend;

    assign out_fire   = out_valid && out_ready;
    assign both_pend  = pend_a_reg && pend_b_reg;
    // result stage is free next cycle
    assign drain      = !out_valid || (out_fire && !(pend_a_reg && pend_b_reg));
    assign s1_advance = s1_valid_reg && drain;
    assign in_ready   = !s1_valid_reg || drain;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pix_reg   <= in_pix;
            s1_col_reg   <= col_reg;
            s1_row_reg   <= row_reg;
            s1_above_reg <= has_above;
            s1_last_reg  <= last_row;
            s1_right_reg <= has_right;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_a_reg <= 1'b0;
            pend_b_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            pend_a_reg <= s1_above_reg;
            pend_b_reg <= s1_last_reg;
        end
        else if (out_fire)
        begin
            if (pend_a_reg)
                pend_a_reg <= 1'b0;
            else
                pend_b_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            oa_pix_reg <= s1_right_reg ? ttps_pkg::avg3(above_pix, right_pix, s1_pix_reg)
                                       : above_pix;
            ob_pix_reg <= s1_pix_reg;
            o_col_reg  <= s1_col_reg;
            o_row_reg  <= s1_row_reg;
        end
    end

    ttps_pkg::pixel_t sel_pix;
    logic [RW-1:0]    sel_row;

    always_comb
    begin
        if (pend_a_reg)
        begin
            sel_pix = oa_pix_reg;
            sel_row = o_row_reg - RW'(1);
        end
        else
        begin
            sel_pix = ob_pix_reg;
            sel_row = o_row_reg;
        end
    end

    assign out_valid = pend_a_reg || pend_b_reg;
    assign out_col   = ttps_pkg::POS_W'(o_col_reg);
    assign out_row   = ttps_pkg::POS_W'(sel_row);
    assign out_alpha = sel_pix.alpha;
    assign out_red   = sel_pix.red;
    assign out_green = sel_pix.green;
    assign out_blue  = sel_pix.blue;
    assign run_last  = !(pend_a_reg && pend_b_reg);

    `TTPS_ASSERT_RST(a_quiet_in_reset, !rst_n |-> !out_valid && !s1_valid_reg, "item in reset")
    `TTPS_ASSERT(a_accept_fills_s1, in_fire |=> s1_valid_reg, "accepted item lost")
    `TTPS_ASSERT(a_stalled_s1_holds, s1_valid_reg && !s1_advance |=> s1_valid_reg, "s1 dropped")
    `TTPS_ASSERT(a_second_kept, both_pend && out_fire |=> !pend_a_reg && pend_b_reg, "second lost")
    `TTPS_ASSERT(a_col_steps, in_fire && !x_end |=> col_reg == $past(col_reg) + 1, "column stuck")

endmodule

`default_nettype wire

// ===== bench/tb_three_tap_pixel_smoother.sv =====
`timescale 1ns / 1ps

module tb_three_tap_pixel_smoother;

    import ttps_pkg::*;

    localparam int MAX_SIZE    = 2048;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 1800;
    localparam int QUIET_AFTER = 1550;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 10;

    typedef struct packed {
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        pixel_t           pix;
        logic             last;
    } smoothed_t;

    class smoother_scoreboard;
        pixel_t           row_buf [MAX_SIZE];
        int unsigned      col_pos;
        int unsigned      row_pos;
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        smoothed_t        pending_px [$];
        int unsigned      mismatches;
        int unsigned      results_checked;

        function new();
            col_pos         = 0;
            row_pos         = 0;
            width_reg       = FRAME_WIDTH_RESET;
            height_reg      = FRAME_HEIGHT_RESET;
            mismatches      = 0;
            results_checked = 0;
        endfunction

        function int unsigned clamp_size(logic [CFG_W-1:0] v);
            if (v == 0)
                return 1;
            if (v > MAX_SIZE)
                return MAX_SIZE;
            return v;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_W-1:0] v);
            if (idx == CFG_FRAME_WIDTH)
                width_reg = v;
            else
                height_reg = v;
        endfunction

        // raster position after one pixel
        function void step_position(int unsigned w, int unsigned h,
                                    inout int unsigned c, inout int unsigned r);
            if (c + 1 >= w)
            begin
                c = 0;
                r = (r + 1 >= h) ? 0 : r + 1;
            end
            else
            begin
                c = c + 1;
            end
        endfunction

        function int unsigned frame_remaining();
            int unsigned c;
            int unsigned r;
            int unsigned n;
            c = col_pos;
            r = row_pos;
            n = 0;
            do
            begin
                step_position(clamp_size(width_reg), clamp_size(height_reg), c, r);
                n++;
            end
            while (!(c == 0 && r == 0) && n < 100000);
            return n;
        endfunction

        function logic [CHAN_W-1:0] mean3(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b,
                                          logic [CHAN_W-1:0] c);
            int unsigned total;
            total = a + b + c;
            return CHAN_W'(total / 3);
        endfunction

        function void note_pixel(pixel_t p);
            int unsigned w;
            int unsigned h;
            bit          last_row;
            pixel_t      above;
            pixel_t      blend;
            smoothed_t   res;
            w = clamp_size(width_reg);
            h = clamp_size(height_reg);
            last_row = (row_pos + 1 >= h);
            if (row_pos >= 1)
            begin
                above = row_buf[col_pos];
                blend = above;
                // right neighbor missing or row past the frame: pass through
                if (col_pos + 1 < w && row_pos < h)
                begin
                    blend.alpha = mean3(above.alpha, row_buf[col_pos + 1].alpha, p.alpha);
                    blend.red   = mean3(above.red,   row_buf[col_pos + 1].red,   p.red);
                    blend.green = mean3(above.green, row_buf[col_pos + 1].green, p.green);
                    blend.blue  = mean3(above.blue,  row_buf[col_pos + 1].blue,  p.blue);
                end
                res.col  = POS_W'(col_pos);
                res.row  = POS_W'(row_pos - 1);
                res.pix  = blend;
                res.last = !last_row;
                pending_px.push_back(res);
            end
            if (last_row)
            begin
                res.col  = POS_W'(col_pos);
                res.row  = POS_W'(row_pos);
                res.pix  = p;
                res.last = 1'b1;
                pending_px.push_back(res);
            end
            row_buf[col_pos] = p;
            step_position(w, h, col_pos, row_pos);
        endfunction

        function void check_result(smoothed_t got);
            smoothed_t want;
            results_checked++;
            if (pending_px.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: col %0d row %0d pix %h last %0d",
                             got.col, got.row, got.pix, got.last);
                return;
            end
            want = pending_px.pop_front();
            if (got.col !== want.col || got.row !== want.row
                || got.pix.alpha !== want.pix.alpha
                || got.pix.red !== want.pix.red || got.pix.green !== want.pix.green
                || got.pix.blue !== want.pix.blue || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected col %0d row %0d pix %h last %0d, ",
                              "got col %0d row %0d pix %h last %0d"},
                             want.col, want.row, want.pix, want.last,
                             got.col, got.row, got.pix, got.last);
            end
        endfunction

        function int unsigned pending();
            return pending_px.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [CHAN_W-1:0]    in_alpha;
    logic [CHAN_W-1:0]    in_red;
    logic [CHAN_W-1:0]    in_green;
    logic [CHAN_W-1:0]    in_blue;
    logic                 out_valid;
    logic                 out_ready;
    logic [POS_W-1:0]     out_col;
    logic [POS_W-1:0]     out_row;
    logic [CHAN_W-1:0]    out_alpha;
    logic [CHAN_W-1:0]    out_red;
    logic [CHAN_W-1:0]    out_green;
    logic [CHAN_W-1:0]    out_blue;
    logic                 run_last;

    smoother_scoreboard sb;
    int unsigned        items_sent;
    int unsigned        cycle_count;
    bit                 no_gaps;
    bit                 hold_request;

    three_tap_pixel_smoother dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_alpha  (in_alpha),
        .in_red    (in_red),
        .in_green  (in_green),
        .in_blue   (in_blue),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_col   (out_col),
        .out_row   (out_row),
        .out_alpha (out_alpha),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .run_last  (run_last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        smoothed_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.col      = out_col;
            got.row      = out_row;
            got.pix      = '{blue: out_blue, green: out_green, red: out_red, alpha: out_alpha};
            got.last     = run_last;
            sb.check_result(got);
        end
    end

    // receiver: random stall bursts plus one long hold-off on request
    initial
    begin
        int unsigned stall_left;
        int unsigned held;
        stall_left = 0;
        out_ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_ready = 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(negedge clk);
                hold_request = 1'b0;
            end
            else if (stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else if (!no_gaps && $urandom_range(0, 5) == 0)
            begin
                out_ready  = 1'b0;
                stall_left = $urandom_range(0, 4);
            end
            else
            begin
                out_ready = 1'b1;
            end
        end
    end

    function automatic pixel_t any_pixel();
        pixel_t p;
        logic [CHAN_W-1:0] ch [4];
        for (int k = 0; k < 4; k++)
        begin
            case ($urandom_range(0, 7))
                0: ch[k] = '0;
                1: ch[k] = '1;
                default: ch[k] = CHAN_W'($urandom);
            endcase
        end
        p.alpha = ch[0];
        p.red   = ch[1];
        p.green = ch[2];
        p.blue  = ch[3];
        return p;
    endfunction

    task automatic write_register(cfg_index_t idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic push_pixel(pixel_t p);
        int unsigned gap;
        @(negedge clk);
        in_valid = 1'b1;
        in_alpha = p.alpha;
        in_red   = p.red;
        in_green = p.green;
        in_blue  = p.blue;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_pixel(p);
        items_sent++;
        if (!no_gaps && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 5);
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic stream_phase(int unsigned count);
        repeat (count) push_pixel(any_pixel());
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // row 0 pixels give no item unless row 0 is the last row, so give the pipe time after the queue empties
    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic set_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        write_register(CFG_FRAME_WIDTH, w);
        write_register(CFG_FRAME_HEIGHT, h);
    endtask

    initial
    begin
        logic [CFG_W-1:0] new_w;
        logic [CFG_W-1:0] new_h;
        int unsigned      area;
        int unsigned      count;
        bit               pressure_done;

        sb            = new();
        items_sent    = 0;
        cycle_count   = 0;
        no_gaps       = 1'b0;
        hold_request  = 1'b0;
        pressure_done = 1'b0;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_FRAME_WIDTH;
        cfg_data      = '0;
        in_valid      = 1'b0;
        in_alpha      = '0;
        in_red        = '0;
        in_green      = '0;
        in_blue       = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // 3x2 frame: full-scale sums and missing right neighbor
        set_size(12'd3, 12'd2);
        push_pixel(pixel_t'(32'hFFFF_FFFF));
        push_pixel(pixel_t'(32'h0000_0000));
        push_pixel(pixel_t'(32'h017F_FE80));
        push_pixel(pixel_t'(32'hFFFF_FFFF));
        push_pixel(pixel_t'(32'hFFFF_FFFF));
        push_pixel(pixel_t'(32'h0000_0000));
        stream_phase(0);
        wait_drained();

        // zero sizes act as 1x1
        set_size(12'd0, 12'd0);
        stream_phase(2);
        wait_drained();

        // oversize saturates, then shrink leaves the column past the width
        set_size(12'hFFF, 12'hFFF);
        stream_phase(4);
        wait_drained();
        set_size(12'd2, 12'd2);
        stream_phase(3);
        wait_drained();

        // height shrink puts the current row past the last row
        set_size(12'd2, 12'd4);
        stream_phase(4);
        wait_drained();
        write_register(CFG_FRAME_HEIGHT, 12'd2);
        stream_phase(2);
        wait_drained();

        set_size(12'd1, 12'd2048);
        stream_phase(3);
        wait_drained();

        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= QUIET_AFTER)
                no_gaps = 1'b1;
            new_w = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 4095))
                                                : CFG_W'($urandom_range(1, 12));
            new_h = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 4095))
                                                : CFG_W'($urandom_range(1, 6));
            if (!pressure_done && items_sent >= 600)
            begin
                new_w = 12'd6;
                new_h = 12'd3;
            end
            // widening mid-frame would read line entries never written
            if (sb.row_pos != 0 && sb.clamp_size(new_w) > sb.clamp_size(sb.width_reg))
                new_w = sb.width_reg;
            set_size(new_w, new_h);
            area = sb.clamp_size(new_w) * sb.clamp_size(new_h);
            if (!pressure_done && items_sent >= 600)
            begin
                count         = 150;
                pressure_done = 1'b1;
                hold_request  = 1'b1;
            end
            else if (area > 120)
                count = $urandom_range(3, 60);
            else if ($urandom_range(0, 4) == 0)
                count = $urandom_range(1, 30);
            else
                count = sb.frame_remaining() + area * $urandom_range(0, 2);
            stream_phase(count);
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
